FILE: design/sdf_pkg.sv
// Package for the string duplicate filter.
// Holds shared constants, the compare unit's operation codes and its request/response
// structs. Depends on nothing.
`timescale 1ns / 1ps

package sdf_pkg;

	localparam int WORD_BYTES  = 128;
	localparam int MAX_WORDS   = 64;
	localparam int CHAR_W      = 8;
	localparam int SLOT_OUT_W  = 6;
	localparam int COUNT_OUT_W = 7;

	localparam logic [CHAR_W-1:0] END_OF_WORD = 8'h00;

	typedef enum logic {
		CMP_LEN,
		CMP_BYTE
	} cmp_op_t;

	typedef struct packed {
		cmp_op_t           op;
		logic [7:0]        len_a;
		logic [7:0]        len_b;
		logic [CHAR_W-1:0] byte_a;
		logic [CHAR_W-1:0] byte_b;
		logic [7:0]        idx;
		logic [7:0]        last_idx;
	} cmp_req_t;

	typedef struct packed {
		logic eq;
		logic last;
	} cmp_rsp_t;

endpackage

FILE: design/sdf_in_if.sv
// Input channel of the string duplicate filter: one character per transaction.
// Depends on sdf_pkg.
`timescale 1ns / 1ps

interface sdf_in_if;
	logic                      valid;
	logic                      ready;
	logic [sdf_pkg::CHAR_W-1:0] char_code;
	logic                      new_list;

	modport source (output valid, output char_code, output new_list, input ready);
	modport sink   (input valid, input char_code, input new_list, output ready);
endinterface

FILE: design/sdf_out_if.sv
// Result channel of the string duplicate filter: one transaction per ended word.
// Depends on sdf_pkg.
`timescale 1ns / 1ps

interface sdf_out_if;
	logic                           valid;
	logic                           ready;
	logic                           is_duplicate;
	logic [sdf_pkg::SLOT_OUT_W-1:0]  first_slot;
	logic [sdf_pkg::COUNT_OUT_W-1:0] distinct_count;
	logic                           table_full;
	logic                           truncated;

	modport source (output valid, output is_duplicate, output first_slot,
		output distinct_count, output table_full, output truncated, input ready);
	modport sink   (input valid, input is_duplicate, input first_slot,
		input distinct_count, input table_full, input truncated, output ready);
endinterface

FILE: design/sdf_ram.sv
// Generic single-write, single-read memory with registered read data.
// Used for the word buffer, the word store and the stored lengths. No dependencies.
`timescale 1ns / 1ps

module sdf_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/sdf_cmp.sv
// Shared compare unit: length or byte equality and last-index detection.
// Depends on sdf_pkg.
`timescale 1ns / 1ps

module sdf_cmp (
	input  sdf_pkg::cmp_req_t req,
	output sdf_pkg::cmp_rsp_t rsp
);

	logic [7:0] op_a;
	logic [7:0] op_b;

	always_comb begin
		case (req.op)
			sdf_pkg::CMP_LEN: begin
				op_a = req.len_a;
				op_b = req.len_b;
			end
			sdf_pkg::CMP_BYTE: begin
				op_a = req.byte_a;
				op_b = req.byte_b;
			end
			default: begin
				op_a = req.byte_a;
				op_b = req.byte_b;
			end
		endcase
		rsp.eq   = (op_a == op_b);
		rsp.last = (req.idx == req.last_idx);
	end

endmodule

FILE: design/string_duplicate_filter.sv
// String duplicate filter: removes repeated words from a list, keeping first occurrences.
// Top level: sequencer, word buffer, word store, stored lengths and the shared compare unit.
// Depends on sdf_pkg, sdf_in_if, sdf_out_if, sdf_ram, sdf_cmp.
//
// Usage:
//   chars carries one byte per transaction; a zero byte ends the current word. new_list set
//   on a transaction clears the distinct-word table and the current word first.
//   A nonzero byte produces no result; bytes past WORD_BYTES-1 are dropped and mark the
//   word truncated.
//   An ending byte starts a scan of the table until a match: each stored word gets a length
//   check, plus a byte-by-byte compare when lengths match. If the table has room, a new word
//   is then copied into the store byte by byte.
//   chars is not ready during the scan and copy.
//   results carries one transaction per ended word from an output register; a stalled
//   receiver holds that register, and the next word end waits only at its final step.
//   Reset clears the table, the current word and the output valid; memory contents are
//   never read before written, so no clearing pass is made.
`timescale 1ns / 1ps

module string_duplicate_filter #(
	parameter int WORD_BYTES = sdf_pkg::WORD_BYTES,
	parameter int MAX_WORDS  = sdf_pkg::MAX_WORDS
) (
	input logic        clk,
	input logic        arst_n,
	sdf_in_if.sink     chars,
	sdf_out_if.source  results
);

	localparam int LEN_W   = $clog2(WORD_BYTES);
	localparam int CNT_W   = $clog2(MAX_WORDS + 1);
	localparam int SLOT_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int STORE_D = MAX_WORDS * WORD_BYTES;
	localparam int ADDR_W  = $clog2(STORE_D);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEN_RD,
		S_LEN_CHK,
		S_BYTE_RD,
		S_BYTE_CHK,
		S_STORE,
		S_COPY_RD,
		S_COPY_WR
	} state_t;

	state_t              state_q;
	logic                finish_q;
	logic [LEN_W-1:0]    len_q;
	logic                ovf_q;
	logic [CNT_W-1:0]    total_q;
	logic [CNT_W-1:0]    slot_q;
	logic [ADDR_W-1:0]   base_q;
	logic [LEN_W-1:0]    idx_q;
	logic                dup_q;
	logic                full_q;
	logic [SLOT_W-1:0]   first_q;

	logic                out_valid_q;
	logic                out_dup_q;
	logic [sdf_pkg::SLOT_OUT_W-1:0]  out_slot_q;
	logic [sdf_pkg::COUNT_OUT_W-1:0] out_count_q;
	logic                out_full_q;
	logic                out_trunc_q;

	logic                in_accept;
	logic [LEN_W-1:0]    eff_len;
	logic                eff_ovf;
	logic [CNT_W-1:0]    eff_total;
	logic                finish_go;

	logic                buf_we;
	logic [LEN_W-1:0]    buf_waddr;
	logic [7:0]          buf_rdata;
	logic [ADDR_W-1:0]   store_addr;
	logic                store_we;
	logic [7:0]          store_rdata;
	logic                slen_we;
	logic [LEN_W-1:0]    slen_rdata;

	sdf_pkg::cmp_req_t   cmp_req;
	sdf_pkg::cmp_rsp_t   cmp_rsp;

	assign chars.ready = (state_q == S_IDLE) && !finish_q;
	assign in_accept   = chars.valid && chars.ready;
	assign eff_len     = chars.new_list ? '0 : len_q;
	assign eff_ovf     = chars.new_list ? 1'b0 : ovf_q;
	assign eff_total   = chars.new_list ? '0 : total_q;
	assign finish_go   = finish_q && (!out_valid_q || results.ready);

	assign buf_we      = in_accept && (chars.char_code != sdf_pkg::END_OF_WORD)
		&& (eff_len < LEN_W'(WORD_BYTES - 1));
	assign buf_waddr   = eff_len;
	assign store_addr  = base_q + ADDR_W'(idx_q);
	assign store_we    = (state_q == S_COPY_WR);
	assign slen_we     = (state_q == S_STORE) && (total_q != CNT_W'(MAX_WORDS));

	assign cmp_req.op       = (state_q == S_LEN_CHK) ? sdf_pkg::CMP_LEN : sdf_pkg::CMP_BYTE;
	assign cmp_req.len_a    = 8'(slen_rdata);
	assign cmp_req.len_b    = 8'(len_q);
	assign cmp_req.byte_a   = store_rdata;
	assign cmp_req.byte_b   = buf_rdata;
	assign cmp_req.idx      = 8'(idx_q);
	assign cmp_req.last_idx = 8'(len_q) - 8'd1;

	sdf_cmp u_cmp (
		.req (cmp_req),
		.rsp (cmp_rsp)
	);

	sdf_ram #(.DEPTH(WORD_BYTES), .WIDTH(8)) u_word_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (chars.char_code),
		.raddr (idx_q),
		.rdata (buf_rdata)
	);

	sdf_ram #(.DEPTH(STORE_D), .WIDTH(8)) u_word_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_addr),
		.wdata (buf_rdata),
		.raddr (store_addr),
		.rdata (store_rdata)
	);

	sdf_ram #(.DEPTH(MAX_WORDS), .WIDTH(LEN_W)) u_stored_len (
		.clk   (clk),
		.we    (slen_we),
		.waddr (total_q[SLOT_W-1:0]),
		.wdata (len_q),
		.raddr (slot_q[SLOT_W-1:0]),
		.rdata (slen_rdata)
	);

	assign results.valid          = out_valid_q;
	assign results.is_duplicate   = out_dup_q;
	assign results.first_slot     = out_slot_q;
	assign results.distinct_count = out_count_q;
	assign results.table_full     = out_full_q;
	assign results.truncated      = out_trunc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			finish_q    <= 1'b0;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			total_q     <= '0;
			slot_q      <= '0;
			base_q      <= '0;
			idx_q       <= '0;
			dup_q       <= 1'b0;
			full_q      <= 1'b0;
			first_q     <= '0;
			out_valid_q <= 1'b0;
			out_dup_q   <= 1'b0;
			out_slot_q  <= '0;
			out_count_q <= '0;
			out_full_q  <= 1'b0;
			out_trunc_q <= 1'b0;
		end else begin
			if (finish_go) begin
				out_valid_q <= 1'b1;
				out_dup_q   <= dup_q;
				out_slot_q  <= sdf_pkg::SLOT_OUT_W'(first_q);
				out_count_q <= sdf_pkg::COUNT_OUT_W'(total_q);
				out_full_q  <= full_q;
				out_trunc_q <= ovf_q;
				len_q       <= '0;
				ovf_q       <= 1'b0;
				finish_q    <= 1'b0;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						total_q <= eff_total;
						if (chars.char_code != sdf_pkg::END_OF_WORD) begin
							if (buf_we) begin
								len_q <= eff_len + LEN_W'(1);
								ovf_q <= eff_ovf;
							end else begin
								len_q <= eff_len;
								ovf_q <= 1'b1;
							end
						end else begin
							len_q   <= eff_len;
							ovf_q   <= eff_ovf;
							slot_q  <= '0;
							base_q  <= '0;
							idx_q   <= '0;
							state_q <= S_LEN_RD;
						end
					end
				end
				S_LEN_RD: begin
					state_q <= (slot_q == total_q) ? S_STORE : S_LEN_CHK;
				end
				S_LEN_CHK: begin
					idx_q <= '0;
					if (!cmp_rsp.eq) begin
						slot_q  <= slot_q + CNT_W'(1);
						base_q  <= base_q + ADDR_W'(WORD_BYTES);
						state_q <= S_LEN_RD;
					end else if (len_q == '0) begin
						dup_q    <= 1'b1;
						full_q   <= 1'b0;
						first_q  <= slot_q[SLOT_W-1:0];
						finish_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_BYTE_RD;
					end
				end
				S_BYTE_RD: begin
					state_q <= S_BYTE_CHK;
				end
				S_BYTE_CHK: begin
					if (!cmp_rsp.eq) begin
						idx_q   <= '0;
						slot_q  <= slot_q + CNT_W'(1);
						base_q  <= base_q + ADDR_W'(WORD_BYTES);
						state_q <= S_LEN_RD;
					end else if (cmp_rsp.last) begin
						dup_q    <= 1'b1;
						full_q   <= 1'b0;
						first_q  <= slot_q[SLOT_W-1:0];
						finish_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						idx_q   <= idx_q + LEN_W'(1);
						state_q <= S_BYTE_RD;
					end
				end
				S_STORE: begin
					dup_q <= 1'b0;
					idx_q <= '0;
					if (total_q == CNT_W'(MAX_WORDS)) begin
						full_q   <= 1'b1;
						first_q  <= '0;
						finish_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						full_q  <= 1'b0;
						first_q <= total_q[SLOT_W-1:0];
						total_q <= total_q + CNT_W'(1);
						if (len_q == '0) begin
							finish_q <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_COPY_RD;
						end
					end
				end
				S_COPY_RD: begin
					state_q <= S_COPY_WR;
				end
				S_COPY_WR: begin
					if (cmp_rsp.last) begin
						finish_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						idx_q   <= idx_q + LEN_W'(1);
						state_q <= S_COPY_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
